@@ rtl/core/pcb_pkg.sv @@
package pcb_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_STAGES = 8;
    localparam int STEPS_PER_STAGE = CORDIC_STEPS / CORDIC_STAGES;

    localparam logic signed [16:0] PI_Q12 = 17'sd12868;
    localparam logic signed [16:0] TWO_PI_Q12 = 17'sd25736;
    localparam logic signed [19:0] PI_Q16 = 20'sd205887;
    localparam logic signed [19:0] HALF_PI_Q16 = 20'sd102944;
    localparam logic signed [19:0] CORDIC_K = 20'sd39797;

    localparam logic [1:0] MODE_STAND = 2'd1;
    localparam logic [1:0] MODE_WALK = 2'd2;

    localparam logic [2:0] REG_GAIN_X = 3'd0;
    localparam logic [2:0] REG_GAIN_Y = 3'd1;
    localparam logic [2:0] REG_GAIN_YAW = 3'd2;
    localparam logic [2:0] REG_LIMIT_VX = 3'd3;
    localparam logic [2:0] REG_LIMIT_VY = 3'd4;
    localparam logic [2:0] REG_LIMIT_VYAW = 3'd5;
    localparam logic [2:0] REG_RUN_ENABLE = 3'd6;

    typedef struct packed {
        logic [15:0] gain_x;
        logic [15:0] gain_y;
        logic [15:0] gain_yaw;
        logic [30:0] limit_vx;
        logic [30:0] limit_vy;
        logic [30:0] limit_vyaw;
        logic        run_enable;
    } cfg_t;

    typedef struct packed {
        logic signed [40:0] vxw;
        logic signed [40:0] vyw;
        logic signed [28:0] vyaw;
    } vel_t;

    typedef struct packed {
        logic signed [19:0] x;
        logic signed [19:0] y;
        logic signed [19:0] z;
        logic               flip;
        vel_t               vel;
    } cord_t;

    function automatic logic signed [19:0] atan_q16(input logic [3:0] i);
        logic signed [19:0] r;
        case (i)
            4'd0:    r = 20'sd51472;
            4'd1:    r = 20'sd30386;
            4'd2:    r = 20'sd16055;
            4'd3:    r = 20'sd8150;
            4'd4:    r = 20'sd4091;
            4'd5:    r = 20'sd2047;
            4'd6:    r = 20'sd1024;
            4'd7:    r = 20'sd512;
            4'd8:    r = 20'sd256;
            4'd9:    r = 20'sd128;
            4'd10:   r = 20'sd64;
            4'd11:   r = 20'sd32;
            4'd12:   r = 20'sd16;
            4'd13:   r = 20'sd8;
            4'd14:   r = 20'sd4;
            default: r = 20'sd2;
        endcase
        return r;
    endfunction

    function automatic cord_t cord_step(input cord_t a, input logic [3:0] i);
        cord_t r;
        logic signed [19:0] dx;
        logic signed [19:0] dy;
        r = a;
        dx = a.y >>> i;
        dy = a.x >>> i;
        if (a.z >= 0)
        begin
            r.x = a.x - dx;
            r.y = a.y + dy;
            r.z = a.z - atan_q16(i);
        end
        else
        begin
            r.x = a.x + dx;
            r.y = a.y - dy;
            r.z = a.z + atan_q16(i);
        end
        return r;
    endfunction

endpackage

@@ rtl/core/pcb_err.sv @@
module pcb_err (
    input  logic               clk,
    input  logic               rst_n,
    input  pcb_pkg::cfg_t      cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] goal_x,
    input  logic signed [31:0] goal_y,
    input  logic signed [14:0] goal_heading,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [14:0] heading,
    output logic               out_valid,
    input  logic               out_ready,
    output pcb_pkg::cord_t     out_data
);

    logic               a_valid_reg;
    logic signed [32:0] ex_reg;
    logic signed [32:0] ey_reg;
    logic signed [16:0] eh_reg;
    logic signed [19:0] z_reg;
    logic               flip_reg;
    logic               a_ready;
    logic               b_valid_reg;
    pcb_pkg::cord_t     b_reg;
    logic               b_ready;

    logic signed [32:0] ex_next;
    logic signed [32:0] ey_next;
    logic signed [16:0] eh_raw;
    logic signed [16:0] eh_next;
    logic signed [19:0] z_raw;
    logic signed [19:0] z_next;
    logic               flip_next;
    logic signed [48:0] px;
    logic signed [48:0] py;
    logic signed [32:0] ph;
    pcb_pkg::cord_t     b_next;

    assign b_ready = !b_valid_reg || out_ready;
    assign a_ready = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    always_comb
    begin
        ex_next = 33'(goal_x) - 33'(pos_x);
        ey_next = 33'(goal_y) - 33'(pos_y);
        eh_raw = 17'(goal_heading) - 17'(heading);
        if (eh_raw > pcb_pkg::PI_Q12)
            eh_next = eh_raw - pcb_pkg::TWO_PI_Q12;
        else if (eh_raw < -pcb_pkg::PI_Q12)
            eh_next = eh_raw + pcb_pkg::TWO_PI_Q12;
        else
            eh_next = eh_raw;
        z_raw = {heading[14], heading, 4'b0000};
        flip_next = 1'b1;
        if (z_raw > pcb_pkg::HALF_PI_Q16)
            z_next = z_raw - pcb_pkg::PI_Q16;
        else if (z_raw < -pcb_pkg::HALF_PI_Q16)
            z_next = z_raw + pcb_pkg::PI_Q16;
        else
        begin
            z_next = z_raw;
            flip_next = 1'b0;
        end
    end

    always_comb
    begin
        px = 49'(ex_reg) * $signed({33'd0, cfg.gain_x});
        py = 49'(ey_reg) * $signed({33'd0, cfg.gain_y});
        ph = 33'(eh_reg) * $signed({17'd0, cfg.gain_yaw});
        b_next.x = pcb_pkg::CORDIC_K;
        b_next.y = '0;
        b_next.z = z_reg;
        b_next.flip = flip_reg;
        b_next.vel.vxw = px[48:8];
        b_next.vel.vyw = py[48:8];
        b_next.vel.vyaw = ph[32:4];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
                a_valid_reg <= in_valid;
            if (b_ready)
                b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            ex_reg <= ex_next;
            ey_reg <= ey_next;
            eh_reg <= eh_next;
            z_reg <= z_next;
            flip_reg <= flip_next;
        end
        if (b_ready && a_valid_reg)
            b_reg <= b_next;
    end

    assign out_valid = b_valid_reg;
    assign out_data = b_reg;

endmodule

@@ rtl/core/pcb_cordic.sv @@
module pcb_cordic (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  pcb_pkg::cord_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output pcb_pkg::cord_t out_data
);

    localparam int N = pcb_pkg::CORDIC_STAGES;
    localparam int S = pcb_pkg::STEPS_PER_STAGE;

    logic           valid_reg [N];
    pcb_pkg::cord_t data_reg [N];
    logic           ready [N];
    logic           src_valid [N];
    pcb_pkg::cord_t src_data [N];
    pcb_pkg::cord_t data_next [N];

    genvar k;
    generate
        for (k = 0; k < N; k++)
        begin : g_stage
            if (k == 0)
            begin : g_first
                assign src_valid[k] = in_valid;
                assign src_data[k] = in_data;
            end
            else
            begin : g_rest
                assign src_valid[k] = valid_reg[k-1];
                assign src_data[k] = data_reg[k-1];
            end

            if (k == N - 1)
            begin : g_last
                assign ready[k] = !valid_reg[k] || out_ready;
            end
            else
            begin : g_mid
                assign ready[k] = !valid_reg[k] || ready[k+1];
            end

            always_comb
            begin
                pcb_pkg::cord_t t;
                t = src_data[k];
                for (int j = 0; j < S; j++)
                    t = pcb_pkg::cord_step(t, 4'(k * S + j));
                data_next[k] = t;
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    valid_reg[k] <= 1'b0;
                else if (ready[k])
                    valid_reg[k] <= src_valid[k];
            end

            always_ff @(posedge clk)
            begin
                if (ready[k] && src_valid[k])
                    data_reg[k] <= data_next[k];
            end
        end
    endgenerate

    assign in_ready = ready[0];
    assign out_valid = valid_reg[N-1];
    assign out_data = data_reg[N-1];

endmodule

@@ rtl/core/pcb_rot.sv @@
module pcb_rot (
    input  logic               clk,
    input  logic               rst_n,
    input  pcb_pkg::cfg_t      cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  pcb_pkg::cord_t     in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         gait_mode,
    output logic signed [31:0] vel_x,
    output logic signed [31:0] vel_y,
    output logic signed [31:0] vel_yaw
);

    logic               a_valid_reg;
    logic signed [60:0] pcx_reg;
    logic signed [60:0] psy_reg;
    logic signed [60:0] pcy_reg;
    logic signed [60:0] psx_reg;
    logic signed [28:0] vyaw_reg;
    logic               a_ready;
    logic               b_valid_reg;
    logic [1:0]         mode_reg;
    logic signed [31:0] vx_reg;
    logic signed [31:0] vy_reg;
    logic signed [31:0] vyaw_out_reg;
    logic               b_ready;

    logic signed [19:0] c;
    logic signed [19:0] s;
    logic signed [61:0] sum_x;
    logic signed [61:0] sum_y;
    logic signed [45:0] vx;
    logic signed [45:0] vy;
    logic signed [45:0] vx_cl;
    logic signed [45:0] vy_cl;
    logic signed [31:0] vyaw_cl;
    logic signed [45:0] lim_x;
    logic signed [45:0] lim_y;
    logic signed [31:0] lim_yaw;
    logic signed [31:0] vyaw_w;

    assign b_ready = !b_valid_reg || out_ready;
    assign a_ready = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    always_comb
    begin
        c = in_data.flip ? -in_data.x : in_data.x;
        s = in_data.flip ? -in_data.y : in_data.y;
    end

    always_comb
    begin
        sum_x = 62'(pcx_reg) + 62'(psy_reg);
        sum_y = 62'(pcy_reg) - 62'(psx_reg);
        vx = sum_x[61:16];
        vy = sum_y[61:16];
        lim_x = $signed({15'd0, cfg.limit_vx});
        lim_y = $signed({15'd0, cfg.limit_vy});
        lim_yaw = $signed({1'b0, cfg.limit_vyaw});
        vyaw_w = 32'(vyaw_reg);
        if (vx > lim_x)
            vx_cl = lim_x;
        else if (vx < -lim_x)
            vx_cl = -lim_x;
        else
            vx_cl = vx;
        if (vy > lim_y)
            vy_cl = lim_y;
        else if (vy < -lim_y)
            vy_cl = -lim_y;
        else
            vy_cl = vy;
        if (vyaw_w > lim_yaw)
            vyaw_cl = lim_yaw;
        else if (vyaw_w < -lim_yaw)
            vyaw_cl = -lim_yaw;
        else
            vyaw_cl = vyaw_w;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
                a_valid_reg <= in_valid;
            if (b_ready)
                b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            pcx_reg <= 61'(c) * 61'(in_data.vel.vxw);
            psy_reg <= 61'(s) * 61'(in_data.vel.vyw);
            pcy_reg <= 61'(c) * 61'(in_data.vel.vyw);
            psx_reg <= 61'(s) * 61'(in_data.vel.vxw);
            vyaw_reg <= in_data.vel.vyaw;
        end
        if (b_ready && a_valid_reg)
        begin
            if (cfg.run_enable)
            begin
                mode_reg <= pcb_pkg::MODE_WALK;
                vx_reg <= vx_cl[31:0];
                vy_reg <= vy_cl[31:0];
                vyaw_out_reg <= vyaw_cl;
            end
            else
            begin
                mode_reg <= pcb_pkg::MODE_STAND;
                vx_reg <= '0;
                vy_reg <= '0;
                vyaw_out_reg <= '0;
            end
        end
    end

    assign out_valid = b_valid_reg;
    assign gait_mode = mode_reg;
    assign vel_x = vx_reg;
    assign vel_y = vy_reg;
    assign vel_yaw = vyaw_out_reg;

endmodule

@@ rtl/core/pose_p_controller_body_frame.sv @@
// channel   dir  handshake               payload
// s_axis    in   s_axis_tvalid/tready    goal_x, goal_y, goal_heading, pos_x, pos_y, heading
// m_axis    out  m_axis_tvalid/tready    gait_mode, vel_x, vel_y, vel_yaw
// cfg       in   cfg_we                  cfg_addr selects register, cfg_wdata value
//
// From input transfer to result the pipeline has two stages of error and gain
// multiply, eight CORDIC stages of two iterations each, one rotation multiply stage
// and one clamp/output stage. Sustains one item per cycle while m_axis_tready is high.
// rst_n clears all stage valid bits and loads register defaults.
// Each stage holds while the stage after it is full and stalled; bubbles are squeezed out.
module pose_p_controller_body_frame (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // goal_x[31:0] goal_y[63:32] goal_heading[78:64] pos_x[110:79] pos_y[142:111]
    // heading[157:143], zero fill above
    input  logic [159:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // gait_mode[1:0] vel_x[33:2] vel_y[65:34] vel_yaw[97:66], zero fill above
    output logic [103:0] m_axis_tdata,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_addr,
    input  logic [30:0]  cfg_wdata
);

    pcb_pkg::cfg_t  cfg_reg;
    logic           e_valid;
    logic           e_ready;
    pcb_pkg::cord_t e_data;
    logic           c_valid;
    logic           c_ready;
    pcb_pkg::cord_t c_data;
    logic [1:0]     gait_mode;
    logic [31:0]    vel_x;
    logic [31:0]    vel_y;
    logic [31:0]    vel_yaw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_x <= 16'd26;
            cfg_reg.gain_y <= 16'd26;
            cfg_reg.gain_yaw <= 16'd26;
            cfg_reg.limit_vx <= 31'd32768;
            cfg_reg.limit_vy <= 31'd32768;
            cfg_reg.limit_vyaw <= 31'd26214;
            cfg_reg.run_enable <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                pcb_pkg::REG_GAIN_X:     cfg_reg.gain_x <= cfg_wdata[15:0];
                pcb_pkg::REG_GAIN_Y:     cfg_reg.gain_y <= cfg_wdata[15:0];
                pcb_pkg::REG_GAIN_YAW:   cfg_reg.gain_yaw <= cfg_wdata[15:0];
                pcb_pkg::REG_LIMIT_VX:   cfg_reg.limit_vx <= cfg_wdata;
                pcb_pkg::REG_LIMIT_VY:   cfg_reg.limit_vy <= cfg_wdata;
                pcb_pkg::REG_LIMIT_VYAW: cfg_reg.limit_vyaw <= cfg_wdata;
                pcb_pkg::REG_RUN_ENABLE: cfg_reg.run_enable <= cfg_wdata[0];
                default:                 ;
            endcase
        end
    end

    pcb_err u_err (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .goal_x       (s_axis_tdata[31:0]),
        .goal_y       (s_axis_tdata[63:32]),
        .goal_heading (s_axis_tdata[78:64]),
        .pos_x        (s_axis_tdata[110:79]),
        .pos_y        (s_axis_tdata[142:111]),
        .heading      (s_axis_tdata[157:143]),
        .out_valid    (e_valid),
        .out_ready    (e_ready),
        .out_data     (e_data)
    );

    pcb_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (e_valid),
        .in_ready  (e_ready),
        .in_data   (e_data),
        .out_valid (c_valid),
        .out_ready (c_ready),
        .out_data  (c_data)
    );

    pcb_rot u_rot (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (c_valid),
        .in_ready  (c_ready),
        .in_data   (c_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .gait_mode (gait_mode),
        .vel_x     (vel_x),
        .vel_y     (vel_y),
        .vel_yaw   (vel_yaw)
    );

    assign m_axis_tdata = {6'd0, vel_yaw, vel_y, vel_x, gait_mode};

    a_mode_legal: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (gait_mode == pcb_pkg::MODE_STAND || gait_mode == pcb_pkg::MODE_WALK))
        else $error("illegal gait_mode");

    a_stand_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && gait_mode == pcb_pkg::MODE_STAND)
        |-> (vel_x == '0 && vel_y == '0 && vel_yaw == '0))
        else $error("stand still with nonzero velocity");

    a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result dropped under stall");

endmodule

@@ tb/tb.sv @@
module tb;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] vel_x;
        logic [31:0] vel_y;
        logic [31:0] vel_yaw;
    } cmd_t;

    class pose_board;
        longint gain_x, gain_y, gain_yaw;
        longint limit_vx, limit_vy, limit_vyaw;
        bit run_enable;
        cmd_t expected[$];
        int errors;
        int checked;
        longint atan_tab[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                 256, 128, 64, 32, 16, 8, 4, 2};

        function new();
            gain_x = 26;
            gain_y = 26;
            gain_yaw = 26;
            limit_vx = 32768;
            limit_vy = 32768;
            limit_vyaw = 26214;
            run_enable = 0;
            errors = 0;
            checked = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [30:0] v);
            case (idx)
                pcb_pkg::REG_GAIN_X:     gain_x = v[15:0];
                pcb_pkg::REG_GAIN_Y:     gain_y = v[15:0];
                pcb_pkg::REG_GAIN_YAW:   gain_yaw = v[15:0];
                pcb_pkg::REG_LIMIT_VX:   limit_vx = v;
                pcb_pkg::REG_LIMIT_VY:   limit_vy = v;
                pcb_pkg::REG_LIMIT_VYAW: limit_vyaw = v;
                pcb_pkg::REG_RUN_ENABLE: run_enable = v[0];
                default: ;
            endcase
        endfunction

        function longint clamp(longint v, longint lim);
            if (v > lim)
                return lim;
            if (v < -lim)
                return -lim;
            return v;
        endfunction

        function cmd_t body_command(logic [159:0] d);
            longint gx, gy, gh, px, py, ph, ex, ey, eh;
            longint vxw, vyw, vyaw, x, y, z, dx, dy, vx, vy;
            bit flip;
            cmd_t r;
            gx = longint'($signed(d[31:0]));
            gy = longint'($signed(d[63:32]));
            gh = longint'($signed(d[78:64]));
            px = longint'($signed(d[110:79]));
            py = longint'($signed(d[142:111]));
            ph = longint'($signed(d[157:143]));
            ex = gx - px;
            ey = gy - py;
            eh = gh - ph;
            if (eh > 12868)
                eh -= 25736;
            if (eh < -12868)
                eh += 25736;
            vxw = (ex * gain_x) >>> 8;
            vyw = (ey * gain_y) >>> 8;
            vyaw = (eh * gain_yaw) >>> 4;
            z = ph * 16;
            x = 39797;
            y = 0;
            flip = 0;
            if (z > 102944)
            begin
                z -= 205887;
                flip = 1;
            end
            else if (z < -102944)
            begin
                z += 205887;
                flip = 1;
            end
            for (int i = 0; i < 16; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0)
                begin
                    x -= dx;
                    y += dy;
                    z -= atan_tab[i];
                end
                else
                begin
                    x += dx;
                    y -= dy;
                    z += atan_tab[i];
                end
            end
            if (flip)
            begin
                x = -x;
                y = -y;
            end
            vx = clamp((x * vxw + y * vyw) >>> 16, limit_vx);
            vy = clamp((x * vyw - y * vxw) >>> 16, limit_vy);
            vyaw = clamp(vyaw, limit_vyaw);
            if (run_enable)
            begin
                r.mode = pcb_pkg::MODE_WALK;
                r.vel_x = vx[31:0];
                r.vel_y = vy[31:0];
                r.vel_yaw = vyaw[31:0];
            end
            else
            begin
                r.mode = pcb_pkg::MODE_STAND;
                r.vel_x = '0;
                r.vel_y = '0;
                r.vel_yaw = '0;
            end
            return r;
        endfunction

        function void note_pose(logic [159:0] d);
            expected.push_back(body_command(d));
        endfunction

        function void check_command(logic [103:0] t);
            cmd_t e;
            if (expected.size() == 0)
            begin
                $display("%0t: unexpected transfer %h", $time, t);
                errors++;
                return;
            end
            e = expected.pop_front();
            checked++;
            if (t[1:0] !== e.mode)
            begin
                $display("%0t: gait_mode expected %0d actual %0d", $time, e.mode, t[1:0]);
                errors++;
            end
            if (t[33:2] !== e.vel_x)
            begin
                $display("%0t: vel_x expected %h actual %h", $time, e.vel_x, t[33:2]);
                errors++;
            end
            if (t[65:34] !== e.vel_y)
            begin
                $display("%0t: vel_y expected %h actual %h", $time, e.vel_y, t[65:34]);
                errors++;
            end
            if (t[97:66] !== e.vel_yaw)
            begin
                $display("%0t: vel_yaw expected %h actual %h", $time, e.vel_yaw, t[97:66]);
                errors++;
            end
            if (t[103:98] !== '0)
            begin
                $display("%0t: fill expected 0 actual %h", $time, t[103:98]);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [159:0] s_axis_tdata;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [103:0] m_axis_tdata;
    logic cfg_we;
    logic [2:0] cfg_addr;
    logic [30:0] cfg_wdata;

    pose_board board;
    bit steady;
    bit long_hold_req;
    int hold_left;
    int sent;

    pose_p_controller_body_frame dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we),
        .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20000000;
        $display("Simulation FAILED");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                board.note_pose(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                board.check_command(m_axis_tdata);
        end
    end

    initial
    begin
        m_axis_tready = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 0;
            end
            else if (long_hold_req)
            begin
                long_hold_req = 0;
                hold_left = 300;
                m_axis_tready <= 0;
            end
            else
                m_axis_tready <= steady || ($urandom_range(99) >= 29);
        end
    end

    function automatic logic [159:0] pose(logic [31:0] gx, logic [31:0] gy, logic [14:0] gh,
                                          logic [31:0] px, logic [31:0] py, logic [14:0] ph);
        return {2'b00, ph, py, px, gh, gy, gx};
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(2097152)) - 1048576);
            2: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
            default: return 32'($signed($urandom_range(400000)) - 200000);
        endcase
    endfunction

    function automatic logic [14:0] rand_heading();
        if ($urandom_range(9) == 0)
            return 15'($urandom);
        return 15'($signed($urandom_range(25736)) - 12868);
    endfunction

    task automatic send_pose(logic [159:0] d);
        while (!steady && $urandom_range(99) < 29)
        begin
            s_axis_tvalid <= 0;
            s_axis_tdata <= 160'($urandom);
            @(posedge clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= d;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sent++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        do
            @(posedge clk);
        while (board.expected.size() != 0);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_config(logic [30:0] gx, logic [30:0] gy, logic [30:0] gw,
                              logic [30:0] lx, logic [30:0] ly, logic [30:0] lw, logic [30:0] run);
        logic [30:0] vals[8];
        vals = '{gx, gy, gw, lx, ly, lw, run, 31'($urandom)};
        for (int i = 7; i >= 0; i--)
        begin
            cfg_we <= 1;
            cfg_addr <= 3'(i);
            cfg_wdata <= vals[i];
            board.write_reg(3'(i), vals[i]);
            @(posedge clk);
        end
        cfg_we <= 0;
        @(posedge clk);
    endtask

    task automatic random_phase(int n, bit pause_mid);
        logic [31:0] px, py;
        for (int k = 0; k < n; k++)
        begin
            if (pause_mid && k == n / 2)
            begin
                s_axis_tvalid <= 0;
                do
                    @(posedge clk);
                while (board.expected.size() != 0);
            end
            px = rand_coord();
            py = rand_coord();
            if ($urandom_range(1))
                send_pose(pose(px + 32'($signed($urandom_range(262144)) - 131072),
                               py + 32'($signed($urandom_range(262144)) - 131072),
                               rand_heading(), px, py, rand_heading()));
            else
                send_pose(pose(rand_coord(), rand_coord(), rand_heading(),
                               px, py, rand_heading()));
        end
    endtask

    initial
    begin
        logic [159:0] directed[$];
        board = new();
        steady = 0;
        long_hold_req = 0;
        sent = 0;
        rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        cfg_we = 0;
        cfg_addr = '0;
        cfg_wdata = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        directed = '{
            pose(0, 0, 0, 0, 0, 0),
            pose(32'h7fffffff, 32'h7fffffff, 12868, 32'h80000000, 32'h80000000, -12868),
            pose(32'h80000000, 32'h80000000, -12868, 32'h7fffffff, 32'h7fffffff, 12868),
            pose(65536, 0, 15'h3fff, 0, 0, 15'h4000),
            pose(0, 65536, 15'h4000, 0, 0, 15'h3fff),
            pose(65536, 65536, 12869, 0, 0, -12868),
            pose(-65536, 32768, 0, 0, 0, 6434),
            pose(32768, -65536, 0, 0, 0, -6434),
            pose(131072, 0, 100, 0, 0, 12868),
            pose(0, 131072, -100, 0, 0, -12868),
            pose(1, -1, 1, 0, 0, -1)
        };
        foreach (directed[i])
            send_pose(directed[i]);
        drain();
        set_config(26, 26, 26, 32768, 32768, 26214, 1);
        foreach (directed[i])
            send_pose(directed[i]);
        drain();
        set_config(31'h7fffffff, 31'h7fffffff, 31'h7fffffff,
                   31'h7fffffff, 31'h7fffffff, 31'h7fffffff, 31'h7ffffffe | 1);
        foreach (directed[i])
            send_pose(directed[i]);
        drain();
        set_config(0, 0, 0, 0, 0, 0, 1);
        random_phase(20, 0);
        drain();

        for (int p = 0; p < 8; p++)
        begin
            if ($urandom_range(2) == 0)
                set_config(31'($urandom), 31'($urandom), 31'($urandom), 31'($urandom),
                           31'($urandom), 31'($urandom), 31'(p != 5));
            else
                set_config(31'($urandom_range(1024)), 31'($urandom_range(1024)),
                           31'($urandom_range(4096)),
                           31'($urandom_range(200000)), 31'($urandom_range(200000)),
                           31'($urandom_range(100000)), 31'(p != 5));
            steady = (p == 2);
            if (p == 3)
                long_hold_req = 1;
            random_phase(110, p == 4);
            drain();
            steady = 0;
        end

        $display("Covered %0d pose transfers, %0d commands checked, over reset, extreme,",
                 sent, board.checked);
        $display("zero and random gain/limit settings with run enabled and disabled.");
        if (board.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
